### sv/iteration_count_hsv_colormap_macros.svh
// Assertion macros for the iteration count HSV colormap block.
`ifndef ITERATION_COUNT_HSV_COLORMAP_MACROS_SVH
`define ITERATION_COUNT_HSV_COLORMAP_MACROS_SVH
`ifndef SYNTH
`define ICM_ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("icm: same-cycle check failed");
`define ICM_ASSERT_NXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("icm: next-cycle check failed");
`else
`define ICM_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define ICM_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

### sv/icm_pkg.sv
// Shared constants, types and helper functions of the iteration count colormap.
`default_nettype none
package icm_pkg;
	localparam int FRACTION_BITS = 16;
	localparam int SPAN_BITS = 24;
	localparam int COUNT_W = 32;
	localparam int SPAN_REG_W = 24;
	localparam int WIDE_W = 48;
	localparam int MODE_W = 7;
	localparam int GAIN_W = 16;
	localparam int GAIN_SHIFT = 10;
	localparam int LOG_FRAC = 24;
	// Mantissa in [1,2) with 30 fraction bits.
	localparam int MANT_W = 31;
	localparam int EXP_W = $clog2(SPAN_BITS);
	localparam int LOG_W = EXP_W + LOG_FRAC;
	localparam int CH_W = FRACTION_BITS + 1;
	localparam logic [CH_W-1:0] FONE = CH_W'(1) << FRACTION_BITS;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd5;

	localparam logic [1:0] CLS_COLOR  = 2'd0;
	localparam logic [1:0] CLS_NONE   = 2'd1;
	localparam logic [1:0] CLS_INSIDE = 2'd2;

	localparam int MODE_INV_BASE = 0;
	localparam int MODE_LOG_BASE = 3;
	localparam int MODE_HALVE = 6;

	typedef struct packed {
		logic [COUNT_W-1:0]   low_bound;
		logic [SPAN_BITS-1:0] span;
		logic [COUNT_W-1:0]   max_iter;
		logic [MODE_W-1:0]    mode;
		logic [WIDE_W-1:0]    offset;
		logic [WIDE_W-1:0]    gain;
	} cfg_t;

	function automatic logic [EXP_W-1:0] msb_index(input logic [SPAN_BITS-1:0] x);
		logic [EXP_W-1:0] n;
		n = '0;
		for (int i = 1; i < SPAN_BITS; i++) begin
			if (x[i]) n = EXP_W'(i);
		end
		return n;
	endfunction

	function automatic logic [MANT_W-1:0] normalize(input logic [SPAN_BITS-1:0] x,
			input logic [EXP_W-1:0] n);
		logic [SPAN_BITS+MANT_W-2:0] w;
		w = {x, (MANT_W-1)'(0)} >> n;
		return w[MANT_W-1:0];
	endfunction

	// One squaring step of the log2 recurrence: {result bit, next mantissa}.
	function automatic logic [MANT_W:0] square_step(input logic [MANT_W-1:0] m);
		logic [2*MANT_W-1:0] sq;
		logic [MANT_W:0] t;
		sq = (2*MANT_W)'(m) * (2*MANT_W)'(m);
		t = sq[2*MANT_W-1:MANT_W-1];
		if (t[MANT_W]) begin
			return {1'b1, t[MANT_W:1]};
		end
		return {1'b0, t[MANT_W-1:0]};
	endfunction
endpackage
`default_nettype wire

### sv/iteration_count_hsv_colormap.sv
// Top level of the iteration count to HSV colormap with its configuration registers.
`default_nettype none
// Streams one escape iteration count per pixel and returns its RGB colour, class and
// dark/pale flags. One pixel enters per clock while the output is not stalled; each
// result passes classification and bit-serial modulo, log2 squaring, fraction division
// and gain and colour conversion, in that order. When the output is stalled the whole
// pipeline holds, so in_ready follows out_ready while a result waits. A separate
// sequential squaring unit builds the log2 of the span after reset and after every
// span write, well before any pixel reaches the divider. The user must write registers
// through the cfg channel only while no pixels are in flight; the block does not enforce it.
module iteration_count_hsv_colormap (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [icm_pkg::COUNT_W-1:0]   iteration_count,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         red,
	output logic [7:0]                         green,
	output logic [7:0]                         blue,
	output logic [1:0]                         pixel_class,
	output logic                               dark_flag,
	output logic                               pale_flag,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [icm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [icm_pkg::WIDE_W-1:0]    cfg_data
);
	import icm_pkg::*;

	`include "iteration_count_hsv_colormap_macros.svh"

	logic [COUNT_W-1:0]    low_q;
	logic [SPAN_REG_W-1:0] span_q;
	logic [COUNT_W-1:0]    max_q;
	logic [MODE_W-1:0]     mode_q;
	logic [WIDE_W-1:0]     offset_q;
	logic [WIDE_W-1:0]     gain_q;

	cfg_t                 cfg;
	logic [SPAN_BITS-1:0] span_raw;
	logic                 en;
	logic                 cfg_xfer;

	assign cfg_ready = 1'b1;
	assign cfg_xfer = cfg_valid && cfg_ready;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			span_q <= SPAN_REG_W'(256);
			max_q <= COUNT_W'(1048576);
			mode_q <= MODE_W'(6);
			offset_q <= WIDE_W'(43253);
			gain_q <= WIDE_W'(5121891);
		end else if (cfg_xfer) begin
			case (cfg_index)
				REG_LOW_BOUND: low_q <= cfg_data[COUNT_W-1:0];
				REG_SPAN: span_q <= cfg_data[SPAN_REG_W-1:0];
				REG_MAX_ITER: max_q <= cfg_data[COUNT_W-1:0];
				REG_MODE: mode_q <= cfg_data[MODE_W-1:0];
				REG_OFFSET: offset_q <= cfg_data;
				REG_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A zero span behaves as a span of one.
	always_comb begin
		span_raw = SPAN_BITS'(span_q);
		cfg.low_bound = low_q;
		cfg.span = (span_raw == '0) ? SPAN_BITS'(1) : span_raw;
		cfg.max_iter = max_q;
		cfg.mode = mode_q;
		cfg.offset = offset_q;
		cfg.gain = gain_q;
	end

	logic                 fr_vld, lg_vld, dv_vld;
	logic [SPAN_BITS-1:0] fr_d, lg_d;
	logic [1:0]           fr_cls, lg_cls, dv_cls;
	logic [LOG_W-1:0]     lg_ld, ls;
	logic [FRACTION_BITS-1:0] lin_frac, log_frac;

	icm_span_log u_span_log (
		.clk(clk), .arst_n(arst_n),
		.start(cfg_xfer && cfg_index == REG_SPAN),
		.span(cfg.span), .ls(ls)
	);

	icm_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg),
		.in_vld(in_valid && in_ready), .count(iteration_count),
		.out_vld(fr_vld), .d(fr_d), .cls(fr_cls)
	);

	icm_log_pipe u_log (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(fr_vld), .in_d(fr_d), .in_cls(fr_cls),
		.out_vld(lg_vld), .d(lg_d), .cls(lg_cls), .ld(lg_ld)
	);

	icm_div_pipe u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg), .ls(ls),
		.in_vld(lg_vld), .in_d(lg_d), .in_cls(lg_cls), .in_ld(lg_ld),
		.out_vld(dv_vld), .cls(dv_cls), .lin_frac(lin_frac), .log_frac(log_frac)
	);

	icm_hsv u_hsv (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg),
		.in_vld(dv_vld), .in_cls(dv_cls), .lin_frac(lin_frac), .log_frac(log_frac),
		.out_vld(out_valid), .red(red), .green(green), .blue(blue),
		.pixel_class(pixel_class), .dark_flag(dark_flag), .pale_flag(pale_flag)
	);

	`ICM_ASSERT_IMP(a_none_is_red, clk, arst_n, out_valid && pixel_class == CLS_NONE,
		red == 8'd255 && green == 8'd0 && blue == 8'd0)
	`ICM_ASSERT_IMP(a_flags_colored, clk, arst_n, out_valid && pixel_class != CLS_COLOR,
		!dark_flag && !pale_flag)
	`ICM_ASSERT_IMP(a_dark_pale_excl, clk, arst_n, out_valid, !(dark_flag && pale_flag))
	`ICM_ASSERT_NXT(a_stall_blocks_in, clk, arst_n, out_valid && !out_ready,
		out_valid && (in_ready == out_ready))
endmodule
`default_nettype wire

### sv/icm_front.sv
// Pixel classification, low bound subtraction and pipelined modulo by the span.
`default_nettype none
module icm_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire icm_pkg::cfg_t                 cfg,
	input  wire logic                          in_vld,
	input  wire logic [icm_pkg::COUNT_W-1:0]   count,
	output logic                               out_vld,
	output logic [icm_pkg::SPAN_BITS-1:0]      d,
	output logic [1:0]                         cls
);
	import icm_pkg::*;

	logic                 vld_s [0:COUNT_W];
	logic [1:0]           cls_s [0:COUNT_W];
	logic [SPAN_BITS-1:0] rem_s [0:COUNT_W];
	logic [COUNT_W-1:0]   dif_s [0:COUNT_W-1];

	logic               in_set;
	logic [COUNT_W-1:0] lim;
	logic [1:0]         cls_c;
	logic [COUNT_W-1:0] dif_c;

	always_comb begin
		in_set = (count == cfg.max_iter);
		lim = '0;
		if (cfg.mode[MODE_HALVE]) begin
			for (int k = 1; k < COUNT_W; k++) begin
				lim = cfg.max_iter >> k;
				if (lim > COUNT_W'(1) && count == lim) in_set = 1'b1;
			end
		end
		if (&count) cls_c = CLS_NONE;
		else if (in_set) cls_c = CLS_INSIDE;
		else cls_c = CLS_COLOR;
		dif_c = (count < cfg.low_bound) ? '0 : count - cfg.low_bound;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s[0] <= cls_c;
			dif_s[0] <= dif_c;
			rem_s[0] <= '0;
		end
	end

	// Restoring remainder, one dividend bit per stage, most significant first.
	for (genvar k = 1; k <= COUNT_W; k++) begin : g_mod
		logic [SPAN_BITS:0] t;
		logic [SPAN_BITS:0] r;
		always_comb begin
			t = {rem_s[k-1], dif_s[k-1][COUNT_W-1]};
			r = (t >= {1'b0, cfg.span}) ? t - {1'b0, cfg.span} : t;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cls_s[k] <= cls_s[k-1];
				rem_s[k] <= r[SPAN_BITS-1:0];
			end
		end
		if (k < COUNT_W) begin : g_shift
			always_ff @(posedge clk) begin
				if (en) dif_s[k] <= {dif_s[k-1][COUNT_W-2:0], 1'b0};
			end
		end
	end

	assign out_vld = vld_s[COUNT_W];
	assign cls = cls_s[COUNT_W];
	assign d = rem_s[COUNT_W];
endmodule
`default_nettype wire

### sv/icm_log_pipe.sv
// Pipelined fixed-point log2 of the reduced count, one result bit per stage.
`default_nettype none
module icm_log_pipe (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_vld,
	input  wire logic [icm_pkg::SPAN_BITS-1:0] in_d,
	input  wire logic [1:0]                   in_cls,
	output logic                              out_vld,
	output logic [icm_pkg::SPAN_BITS-1:0]     d,
	output logic [1:0]                        cls,
	output logic [icm_pkg::LOG_W-1:0]         ld
);
	import icm_pkg::*;

	logic                 vld_s1;
	logic [1:0]           cls_s1;
	logic [SPAN_BITS-1:0] d_s1;
	logic [EXP_W-1:0]     exp_s1;

	logic                 vld_s [0:LOG_FRAC];
	logic [1:0]           cls_s [0:LOG_FRAC];
	logic [SPAN_BITS-1:0] d_s [0:LOG_FRAC];
	logic [MANT_W-1:0]    mant_s [0:LOG_FRAC];
	logic [LOG_W-1:0]     res_s [0:LOG_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s1 <= in_cls;
			d_s1 <= in_d;
			exp_s1 <= msb_index(in_d);
			cls_s[0] <= cls_s1;
			d_s[0] <= d_s1;
			mant_s[0] <= normalize(d_s1, exp_s1);
			res_s[0] <= {exp_s1, LOG_FRAC'(0)};
		end
	end

	for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
		logic [MANT_W:0] step;
		assign step = square_step(mant_s[k-1]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cls_s[k] <= cls_s[k-1];
				d_s[k] <= d_s[k-1];
				mant_s[k] <= step[MANT_W-1:0];
				res_s[k] <= res_s[k-1] | (LOG_W'(step[MANT_W]) << (LOG_FRAC - k));
			end
		end
	end

	assign out_vld = vld_s[LOG_FRAC];
	assign cls = cls_s[LOG_FRAC];
	assign d = d_s[LOG_FRAC];
	assign ld = res_s[LOG_FRAC];
endmodule
`default_nettype wire

### sv/icm_span_log.sv
// Sequential log2 of the span, recomputed after reset and after each span write.
`default_nettype none
module icm_span_log (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [icm_pkg::SPAN_BITS-1:0] span,
	output logic [icm_pkg::LOG_W-1:0]          ls
);
	import icm_pkg::*;

	localparam int CNT_W = $clog2(LOG_FRAC);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NORM = 2'd1;
	localparam logic [1:0] ST_ITER = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MANT_W-1:0] mant_q;
	logic [LOG_W-1:0]  res_q;
	logic [MANT_W:0]   step;
	logic [EXP_W-1:0]  n;

	assign step = square_step(mant_q);
	assign n = msb_index(span);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NORM;
			cnt_q <= '0;
		end else if (start) begin
			state_q <= ST_NORM;
		end else begin
			case (state_q)
				ST_NORM: begin
					state_q <= ST_ITER;
					cnt_q <= CNT_W'(LOG_FRAC - 1);
				end
				ST_ITER: begin
					if (cnt_q == '0) state_q <= ST_IDLE;
					else cnt_q <= cnt_q - 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (!start && state_q == ST_NORM) begin
			mant_q <= normalize(span, n);
			res_q <= {n, LOG_FRAC'(0)};
		end else if (!start && state_q == ST_ITER) begin
			mant_q <= step[MANT_W-1:0];
			res_q[cnt_q] <= step[MANT_W];
		end
	end

	assign ls = res_q;
endmodule
`default_nettype wire

### sv/icm_div_pipe.sv
// Pipelined linear and logarithmic fraction dividers, one quotient bit per stage.
`default_nettype none
module icm_div_pipe (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire icm_pkg::cfg_t                 cfg,
	input  wire logic [icm_pkg::LOG_W-1:0]     ls,
	input  wire logic                          in_vld,
	input  wire logic [icm_pkg::SPAN_BITS-1:0] in_d,
	input  wire logic [1:0]                    in_cls,
	input  wire logic [icm_pkg::LOG_W-1:0]     in_ld,
	output logic                               out_vld,
	output logic [1:0]                         cls,
	output logic [icm_pkg::FRACTION_BITS-1:0]  lin_frac,
	output logic [icm_pkg::FRACTION_BITS-1:0]  log_frac
);
	import icm_pkg::*;

	localparam int F = FRACTION_BITS;

	logic                 vld_s [0:F];
	logic [1:0]           cls_s [0:F];
	logic                 zero_s [0:F];
	logic                 sat_s [0:F];
	logic [SPAN_BITS-1:0] lrem_s [0:F];
	logic [LOG_W-1:0]     grem_s [0:F];
	logic [F-1:0]         lquo_s [0:F];
	logic [F-1:0]         gquo_s [0:F];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	// A log ratio of one or more saturates; a zero count gives a zero fraction.
	always_ff @(posedge clk) begin
		if (en) begin
			cls_s[0] <= in_cls;
			zero_s[0] <= (in_d == '0);
			sat_s[0] <= (in_ld >= ls);
			lrem_s[0] <= in_d;
			grem_s[0] <= in_ld;
			lquo_s[0] <= '0;
			gquo_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= F; k++) begin : g_div
		logic [SPAN_BITS:0] lt;
		logic [LOG_W:0]     gt;
		logic               lb;
		logic               gb;
		always_comb begin
			lt = {lrem_s[k-1], 1'b0};
			gt = {grem_s[k-1], 1'b0};
			lb = (lt >= {1'b0, cfg.span});
			gb = (gt >= {1'b0, ls});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cls_s[k] <= cls_s[k-1];
				zero_s[k] <= zero_s[k-1];
				sat_s[k] <= sat_s[k-1];
				lrem_s[k] <= lb ? SPAN_BITS'(lt - {1'b0, cfg.span}) : SPAN_BITS'(lt);
				grem_s[k] <= gb ? LOG_W'(gt - {1'b0, ls}) : LOG_W'(gt);
				lquo_s[k] <= {lquo_s[k-1][F-2:0], lb};
				gquo_s[k] <= {gquo_s[k-1][F-2:0], gb};
			end
		end
	end

	assign out_vld = vld_s[F];
	assign cls = cls_s[F];
	assign lin_frac = lquo_s[F];
	assign log_frac = zero_s[F] ? '0 : (sat_s[F] ? '1 : gquo_s[F]);
endmodule
`default_nettype wire

### sv/icm_hsv.sv
// Gain, offset and wrap of the three channels, then HSV to RGB conversion.
`default_nettype none
module icm_hsv (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire icm_pkg::cfg_t                cfg,
	input  wire logic                         in_vld,
	input  wire logic [1:0]                   in_cls,
	input  wire logic [icm_pkg::FRACTION_BITS-1:0] lin_frac,
	input  wire logic [icm_pkg::FRACTION_BITS-1:0] log_frac,
	output logic                              out_vld,
	output logic [7:0]                        red,
	output logic [7:0]                        green,
	output logic [7:0]                        blue,
	output logic [1:0]                        pixel_class,
	output logic                              dark_flag,
	output logic                              pale_flag
);
	import icm_pkg::*;

	localparam int F = FRACTION_BITS;
	localparam int PROD_W = GAIN_W + F + 1;
	localparam int OFF_SHIFT = 24 - F;
	localparam int H6_W = CH_W + 3;
	localparam int FL_W = CH_W + 5;
	localparam logic [H6_W-1:0] SIX_ONE = H6_W'(6) << F;
	localparam logic [FL_W-1:0] ONE_W = FL_W'(FONE);
	localparam logic [FL_W-1:0] NINETEEN_ONE = FL_W'(19) << F;

	logic [5:0] vld_q;
	logic [1:0] cls_s1, cls_s2, cls_s3, cls_s4, cls_s5;

	// Stage 1: signed gain times fraction.
	logic [F-1:0]             frac_c [3];
	logic signed [PROD_W-1:0] prod_c [3];
	logic signed [PROD_W-1:0] prod_s1 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			frac_c[i] = cfg.mode[MODE_LOG_BASE+i] ? log_frac : lin_frac;
			prod_c[i] = $signed(cfg.gain[GAIN_W*i +: GAIN_W]) * $signed({1'b0, frac_c[i]});
		end
	end

	// Stage 2: offset, wrap to [0,1), optional inversion.
	logic [23:0]     off_w [3];
	logic [F-1:0]    sum_c [3];
	logic [CH_W-1:0] x_c [3];
	logic [CH_W-1:0] hsv_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off_w[i] = {cfg.offset[16*i +: 16], 8'd0} >> OFF_SHIFT;
			sum_c[i] = off_w[i][F-1:0] + prod_s1[i][F+GAIN_SHIFT-1:GAIN_SHIFT];
			x_c[i] = cfg.mode[MODE_INV_BASE+i] ? FONE - {1'b0, sum_c[i]} : {1'b0, sum_c[i]};
		end
	end

	// Stage 3: hue sector and position, dark and pale tests.
	logic [H6_W-1:0] h6_raw, h6;
	logic [FL_W-1:0] v20, s20;
	logic [2:0]      sec_s3;
	logic [F-1:0]    f_s3;
	logic [CH_W-1:0] s_s3, v_s3;
	logic            dark_s3, pale_s3;

	always_comb begin
		h6_raw = H6_W'(hsv_s2[0]) * H6_W'(6);
		h6 = (h6_raw >= SIX_ONE) ? h6_raw - SIX_ONE : h6_raw;
		v20 = FL_W'(hsv_s2[2]) * FL_W'(20);
		s20 = FL_W'(hsv_s2[1]) * FL_W'(20);
	end

	// Stage 4: s*f, s*(1-f), v*(1-s).
	logic [2*CH_W-1:0] sf_c, sg_c, p_c;
	logic [CH_W-1:0]   a_s4, b_s4, p_s4, v_s4;
	logic [2:0]        sec_s4;
	logic              dark_s4, pale_s4;

	always_comb begin
		sf_c = (2*CH_W)'(s_s3) * (2*CH_W)'(f_s3);
		sg_c = (2*CH_W)'(s_s3) * (2*CH_W)'(FONE - {1'b0, f_s3});
		p_c = (2*CH_W)'(v_s3) * (2*CH_W)'(FONE - s_s3);
	end

	// Stage 5: q and t.
	logic [2*CH_W-1:0] q_c, t_c;
	logic [CH_W-1:0]   q_s5, t_s5, p_s5, v_s5;
	logic [2:0]        sec_s5;
	logic              dark_s5, pale_s5;

	always_comb begin
		q_c = (2*CH_W)'(v_s4) * (2*CH_W)'(FONE - a_s4);
		t_c = (2*CH_W)'(v_s4) * (2*CH_W)'(FONE - b_s4);
	end

	// Stage 6: sector select and scaling to eight bits.
	logic [CH_W-1:0]   r_c, g_c, b_c;
	logic [CH_W+7:0]   r8, g8, b8;

	always_comb begin
		case (sec_s5)
			3'd0: begin r_c = v_s5; g_c = t_s5; b_c = p_s5; end
			3'd1: begin r_c = q_s5; g_c = v_s5; b_c = p_s5; end
			3'd2: begin r_c = p_s5; g_c = v_s5; b_c = t_s5; end
			3'd3: begin r_c = p_s5; g_c = q_s5; b_c = v_s5; end
			3'd4: begin r_c = t_s5; g_c = p_s5; b_c = v_s5; end
			default: begin r_c = v_s5; g_c = p_s5; b_c = q_s5; end
		endcase
		r8 = (CH_W+8)'(r_c) * (CH_W+8)'(255);
		g8 = (CH_W+8)'(g_c) * (CH_W+8)'(255);
		b8 = (CH_W+8)'(b_c) * (CH_W+8)'(255);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s1 <= in_cls;
			prod_s1 <= prod_c;
			cls_s2 <= cls_s1;
			hsv_s2 <= x_c;
			cls_s3 <= cls_s2;
			sec_s3 <= h6[F+2:F];
			f_s3 <= h6[F-1:0];
			s_s3 <= hsv_s2[1];
			v_s3 <= hsv_s2[2];
			dark_s3 <= (v20 < ONE_W);
			pale_s3 <= (v20 > NINETEEN_ONE) && (s20 < ONE_W);
			cls_s4 <= cls_s3;
			a_s4 <= sf_c[F+CH_W-1:F];
			b_s4 <= sg_c[F+CH_W-1:F];
			p_s4 <= p_c[F+CH_W-1:F];
			v_s4 <= v_s3;
			sec_s4 <= sec_s3;
			dark_s4 <= dark_s3;
			pale_s4 <= pale_s3;
			cls_s5 <= cls_s4;
			q_s5 <= q_c[F+CH_W-1:F];
			t_s5 <= t_c[F+CH_W-1:F];
			p_s5 <= p_s4;
			v_s5 <= v_s4;
			sec_s5 <= sec_s4;
			dark_s5 <= dark_s4;
			pale_s5 <= pale_s4;
			pixel_class <= cls_s5;
			if (cls_s5 == CLS_NONE) begin
				red <= 8'd255;
				green <= 8'd0;
				blue <= 8'd0;
			end else if (cls_s5 == CLS_INSIDE) begin
				red <= 8'd0;
				green <= 8'd0;
				blue <= 8'd0;
			end else begin
				red <= r8[F+7:F];
				green <= g8[F+7:F];
				blue <= b8[F+7:F];
			end
			dark_flag <= (cls_s5 == CLS_COLOR) && dark_s5;
			pale_flag <= (cls_s5 == CLS_COLOR) && pale_s5;
		end
	end

	assign out_vld = vld_q[5];
endmodule
`default_nettype wire
